@@ sv/apc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Access pattern classifier package
// Pattern codes, pair class indexes, controller states and the link type that
// joins neighboring history cells.
// ----------------------------------------------------------------------------
package apc_pkg;

	// Width of one recorded offset and of the block size register.
	localparam int unsigned OFFSET_W = 32;

	// Number of pair classes counted in each cell.
	localparam int unsigned NUM_CLASSES = 4;

	// Largest value that the pairs_seen field can show.
	localparam int unsigned PAIRS_MAX = 15;

	// Kept pattern codes as they appear on the result word.
	typedef enum logic [2:0] {
		PAT_UNKNOWN    = 3'd0,
		PAT_SEQUENTIAL = 3'd1,
		PAT_STREAMING  = 3'd2,
		PAT_REUSE      = 3'd3,
		PAT_RANDOM     = 3'd4
	} pattern_t;

	// Bit positions of the one-hot pair class and of the per-class counters.
	localparam int unsigned CLS_SEQ = 0;
	localparam int unsigned CLS_STR = 1;
	localparam int unsigned CLS_REU = 2;
	localparam int unsigned CLS_RND = 3;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

	// Data handed from one history cell to its older neighbor.
	typedef struct packed {
		logic                vld;
		logic [OFFSET_W-1:0] offset;
	} cell_link_t;

endpackage : apc_pkg
`default_nettype wire

@@ sv/access_pattern_classifier.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Access pattern classifier
// Keeps a history of recent access offsets in a chain of cells, classifies
// every adjacent pair and reports the majority access pattern per word.
// ----------------------------------------------------------------------------
// A taken word starts the settle phase (ST_RUN); ST_DONE then loads the result
// into the output reg, and no new word is taken before that, while the per-class
// counts ripple one cell per cycle down the history chain.
// A new word is taken while a finished result still waits in the output reg.
// Reset clears the history valid bits, the held count, the kept pattern
// (unknown) and the block size; the config port is always ready.
// ----------------------------------------------------------------------------
module access_pattern_classifier
	import apc_pkg::*;
#(
	parameter int unsigned HISTORY_DEPTH = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// Input words.
	input  wire logic                in_valid,
	output      logic                in_ready,
	input  wire logic [OFFSET_W-1:0] access_offset,
	// Result words.
	output      logic                out_valid,
	input  wire logic                out_ready,
	output      logic [2:0]          pattern,
	output      logic [3:0]          pairs_seen,
	// Configuration write.
	input  wire logic                cfg_valid,
	output      logic                cfg_ready,
	input  wire logic [OFFSET_W-1:0] block_size
);

	localparam int unsigned CW  = $clog2(HISTORY_DEPTH);
	localparam int unsigned HW  = $clog2(HISTORY_DEPTH + 1);
	localparam int unsigned TCW = (HISTORY_DEPTH > 2) ? $clog2(HISTORY_DEPTH) : 1;

	state_t                         state_q, state_d;
	logic [TCW-1:0]                 wait_q;
	logic [HW-1:0]                  held_q;
	logic [OFFSET_W-1:0]            block_size_q;
	pattern_t                       cur_pat_q;
	logic                           out_valid_q;
	pattern_t                       out_pat_q;
	logic [3:0]                     out_pairs_q;

	logic                           in_acc;
	logic                           out_free;
	logic                           load_out;
	logic                           enough;
	pattern_t                       new_pat;
	logic [3:0]                     pairs_d;
	logic [31:0]                    held_ext;

	cell_link_t                     link [HISTORY_DEPTH+1];
	logic [NUM_CLASSES-1:0][CW-1:0] acc  [HISTORY_DEPTH+1];
	logic [CW-1:0]                  seq_c, str_c, reu_c, rnd_c;

	assign in_acc   = in_valid & in_ready;
	assign out_free = ~out_valid_q | out_ready;
	assign cfg_ready = 1'b1;

	// Block size register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			block_size_q <= block_size;
		end
	end

	// History chain, newest offset in the first cell.
	assign link[0].vld    = in_acc;
	assign link[0].offset = access_offset;
	assign acc[0]         = '0;

	for (genvar g = 0; g < HISTORY_DEPTH; g++) begin : g_cell
		apc_cell #(
			.CW(CW)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.shift_en   (in_acc),
			.link_in    (link[g]),
			.block_size (block_size_q),
			.acc_in     (acc[g]),
			.link_out   (link[g+1]),
			.acc_out    (acc[g+1])
		);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (wait_q == TCW'(HISTORY_DEPTH - 1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Controller outputs.
	always_comb begin
		in_ready = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_RUN:  in_ready = 1'b0;
			ST_DONE: load_out = out_free;
			default: in_ready = 1'b0;
		endcase
	end

	// State, settle counter and held count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wait_q  <= '0;
			held_q  <= '0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				wait_q <= '0;
			end else if (state_q == ST_RUN) begin
				wait_q <= wait_q + 1'b1;
			end
			if (in_acc && held_q != HW'(HISTORY_DEPTH)) begin
				held_q <= held_q + 1'b1;
			end
		end
	end

	// Majority vote over the totals leaving the oldest cell.
	assign seq_c    = acc[HISTORY_DEPTH][CLS_SEQ];
	assign str_c    = acc[HISTORY_DEPTH][CLS_STR];
	assign reu_c    = acc[HISTORY_DEPTH][CLS_REU];
	assign rnd_c    = acc[HISTORY_DEPTH][CLS_RND];
	assign enough   = link[2].vld;
	assign held_ext = 32'(held_q);

	always_comb begin
		if (!enough) begin
			new_pat = cur_pat_q;
		end else if (seq_c > rnd_c && seq_c > str_c && seq_c > reu_c) begin
			new_pat = PAT_SEQUENTIAL;
		end else if (str_c > seq_c && str_c > rnd_c && str_c > reu_c) begin
			new_pat = PAT_STREAMING;
		end else if (reu_c > seq_c && reu_c > str_c && reu_c > rnd_c) begin
			new_pat = PAT_REUSE;
		end else begin
			new_pat = PAT_RANDOM;
		end
		if (!enough) begin
			pairs_d = '0;
		end else if (held_ext > 32'(PAIRS_MAX + 1)) begin
			pairs_d = 4'(PAIRS_MAX);
		end else begin
			pairs_d = 4'(held_ext - 32'd1);
		end
	end

	// Kept pattern and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_pat_q   <= PAT_UNKNOWN;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				cur_pat_q   <= new_pat;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_pat_q   <= new_pat;
			out_pairs_q <= pairs_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign pattern    = out_pat_q;
	assign pairs_seen = out_pairs_q;

	// A taken word always starts the settle phase.
	a_accept_runs: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_RUN))
		else $error("accepted word did not start the settle phase");

	// A result built from at least one pair never reports unknown.
	a_known_pattern: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && pairs_seen != 4'd0) |-> (pattern != PAT_UNKNOWN))
		else $error("classified result reports unknown pattern");

	// Once the chain has settled, the class totals cover every held pair.
	a_totals: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && enough) |->
		((32'(seq_c) + 32'(str_c) + 32'(reu_c) + 32'(rnd_c)) == (held_ext - 32'd1)))
		else $error("class totals do not match held pair count");

	// The held count never passes the history depth.
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_ext <= 32'(HISTORY_DEPTH))
		else $error("held count exceeds history depth");

endmodule : access_pattern_classifier
`default_nettype wire

@@ sv/apc_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Access pattern classifier history cell
// Holds one offset, classifies it against its newer neighbor and adds the
// class to the running per-class counts that ripple down the chain.
// ----------------------------------------------------------------------------
module apc_cell
	import apc_pkg::*;
#(
	parameter int unsigned CW = 4
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            shift_en,
	input  wire cell_link_t                      link_in,
	input  wire logic [OFFSET_W-1:0]             block_size,
	input  wire logic [NUM_CLASSES-1:0][CW-1:0]  acc_in,
	output      cell_link_t                      link_out,
	output      logic [NUM_CLASSES-1:0][CW-1:0]  acc_out
);

	logic [OFFSET_W-1:0]            offset_q;
	logic                           vld_q;
	logic [NUM_CLASSES-1:0]         cls_q;
	logic [NUM_CLASSES-1:0][CW-1:0] acc_q;

	logic [OFFSET_W:0]              diff;
	logic [OFFSET_W-1:0]            mag;
	logic [OFFSET_W-1:0]            quarter;
	logic                           pair_ok;
	logic [NUM_CLASSES-1:0]         cls_d;

	// Offset storage shifts one cell older on every accepted word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (shift_en) begin
			vld_q <= link_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			offset_q <= link_in.offset;
		end
	end

	assign link_out.vld    = vld_q;
	assign link_out.offset = offset_q;

	// Classify the pair formed by the newer neighbor and this cell. Nothing is
	// counted in the cycle a word shifts in, so the newest pair is seen only
	// once the history has moved and not also against the incoming word.
	always_comb begin
		diff    = {1'b0, link_in.offset} - {1'b0, offset_q};
		mag     = (link_in.offset >= offset_q) ? (link_in.offset - offset_q)
		                                       : (offset_q - link_in.offset);
		quarter = block_size >> 2;
		pair_ok = link_in.vld & vld_q & ~shift_en;
		cls_d   = '0;
		if (pair_ok) begin
			if (diff == {1'b0, block_size}) begin
				cls_d[CLS_SEQ] = 1'b1;
			end else if (link_in.offset == offset_q) begin
				cls_d[CLS_REU] = 1'b1;
			end else if (mag < quarter) begin
				cls_d[CLS_STR] = 1'b1;
			end else begin
				cls_d[CLS_RND] = 1'b1;
			end
		end
	end

	// Registered class and running counts handed to the older neighbor.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cls_q <= '0;
			acc_q <= '0;
		end else begin
			cls_q <= cls_d;
			for (int k = 0; k < NUM_CLASSES; k++) begin
				acc_q[k] <= acc_in[k] + CW'(cls_q[k]);
			end
		end
	end

	assign acc_out = acc_q;

endmodule : apc_cell
`default_nettype wire
